@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file snr_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held low.
`define SNR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is checked during reset too.
`define SNR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/snr_pkg.sv @@
// Package for the seven-segment number renderer: item type, register map,
// segment geometry and decimal digit helpers. No dependencies.
`timescale 1ns / 1ps

package snr_pkg;

    localparam int NUM_DIGITS = 10;
    localparam int SLOT_PITCH = 22;
    localparam int NUM_SEGS   = 7;

    localparam logic [2:0] REG_INT_DIGITS  = 3'd0;
    localparam logic [2:0] REG_FRAC_DIGITS = 3'd1;
    localparam logic [2:0] REG_SHOW_GRID   = 3'd2;
    localparam logic [2:0] REG_HANDLE_NEG  = 3'd3;
    localparam logic [2:0] REG_VALUE       = 3'd4;

    localparam logic [3:0]  RST_INT_DIGITS  = 4'd3;
    localparam logic [2:0]  RST_FRAC_DIGITS = 3'd2;
    localparam logic        RST_SHOW_GRID   = 1'b0;
    localparam logic        RST_HANDLE_NEG  = 1'b1;
    localparam logic [30:0] RST_VALUE       = 31'd0;

    localparam logic [1:0] LEVEL_OFF  = 2'd0;
    localparam logic [1:0] LEVEL_GRID = 2'd1;
    localparam logic [1:0] LEVEL_LIT  = 2'd2;

    localparam logic [6:0] SEG_CENTRE = 7'h08;

    localparam logic [4:0] SEG_LO_X [NUM_SEGS] = '{5'd0, 5'd0, 5'd18, 5'd2, 5'd0, 5'd18, 5'd0};
    localparam logic [4:0] SEG_HI_X [NUM_SEGS] = '{5'd20, 5'd2, 5'd20, 5'd18, 5'd2, 5'd20, 5'd20};
    localparam logic [6:0] SEG_LO_Y [NUM_SEGS] = '{7'd48, 7'd25, 7'd25, 7'd24, 7'd0, 7'd0, 7'd0};
    localparam logic [6:0] SEG_HI_Y [NUM_SEGS] = '{7'd50, 7'd50, 7'd50, 7'd26, 7'd25, 7'd25, 7'd2};

    typedef logic [NUM_DIGITS-1:0][3:0] t_bcd;

    typedef struct packed {
        logic signed [7:0] d;          // decimal digit index of the slot
        logic [6:0]        seg_hit;
        logic              slot_ok;
        logic              in_frac;
        logic              blank_zone;
        logic              minus_edge;
    } t_item;

    function automatic logic [6:0] digit_segs(input logic [3:0] dig);
        logic [6:0] segs;
        case (dig)
            4'd0: segs = 7'h77;
            4'd1: segs = 7'h24;
            4'd2: segs = 7'h5D;
            4'd3: segs = 7'h6D;
            4'd4: segs = 7'h2E;
            4'd5: segs = 7'h6B;
            4'd6: segs = 7'h7B;
            4'd7: segs = 7'h25;
            4'd8: segs = 7'h7F;
            4'd9: segs = 7'h6F;
            default: segs = 7'h00;
        endcase
        return segs;
    endfunction

    function automatic logic [3:0] digit_at(input t_bcd digs, input logic signed [7:0] d);
        logic [3:0] dig;
        if (d < 0 || d >= 8'(NUM_DIGITS)) begin
            dig = 4'd0;
        end else begin
            dig = digs[d[3:0]];
        end
        return dig;
    endfunction

    function automatic logic nonzero_at(input logic [NUM_DIGITS-1:0] nz,
                                        input logic signed [7:0] d);
        logic r;
        if (d <= 0) begin
            r = nz[0];
        end else if (d >= 8'(NUM_DIGITS)) begin
            r = 1'b0;
        end else begin
            r = nz[d[3:0]];
        end
        return r;
    endfunction

endpackage

@@ sv/snr_bcd_conv.sv @@
// Binary to decimal converter for the magnitude of the display value.
// Shift-and-add-three, one bit per cycle. Depends on snr_pkg.
`timescale 1ns / 1ps

module snr_bcd_conv import snr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [30:0]           i_value,
    output logic                  o_busy,
    output t_bcd                  o_digits,
    output logic [NUM_DIGITS-1:0] o_nonzero
);

    logic [30:0] r_bin, n_bin;
    t_bcd        r_bcd, n_bcd;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] w_mag;
    t_bcd        w_adj;

    assign w_mag = i_value[30] ? (32'h8000_0000 - {1'b0, i_value}) : {1'b0, i_value};

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            w_adj[i] = (r_bcd[i] >= 4'd5) ? (r_bcd[i] + 4'd3) : r_bcd[i];
        end
        n_bin = r_bin;
        n_bcd = r_bcd;
        n_cnt = r_cnt;
        if (i_start) begin
            n_bin = w_mag[30:0];
            n_bcd = '0;
            n_cnt = 5'd31;
        end else if (r_cnt != 5'd0) begin
            {n_bcd, n_bin} = {w_adj[NUM_DIGITS-1:0], r_bin} << 1;
            n_cnt = r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 5'd0;
            r_bcd <= '0;
            r_bin <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_bcd <= n_bcd;
            r_bin <= n_bin;
        end
    end

    always_comb begin
        o_nonzero[NUM_DIGITS-1] = |r_bcd[NUM_DIGITS-1];
        for (int i = NUM_DIGITS - 2; i >= 0; i--) begin
            o_nonzero[i] = (|r_bcd[i]) | o_nonzero[i+1];
        end
    end

    assign o_busy   = (r_cnt != 5'd0);
    assign o_digits = r_bcd;

endmodule

@@ sv/snr_front.sv @@
// Front stage: accept a pixel position, find its slot and local x,
// test the segment rectangles and classify the slot. Depends on snr_pkg.
`timescale 1ns / 1ps

module snr_front import snr_pkg::*; #(
    parameter int MAX_SLOTS         = 16,
    parameter int VALUE_FRAC_DIGITS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_hold,
    input  logic [8:0] i_pos_x,
    input  logic [6:0] i_pos_y,
    input  logic [3:0] i_int_digits,
    input  logic [2:0] i_frac_digits,
    input  logic       i_handle_neg,
    output logic       o_valid,
    input  logic       i_ready,
    output t_item      o_item
);

    logic              r_valid;
    t_item             r_item, n_item;
    logic [17:0]       w_prod;
    logic [4:0]        w_slot;
    logic [8:0]        w_base;
    logic [4:0]        w_lx;
    logic signed [7:0] w_k;

    // x / 22 through a reciprocal, exact for 9-bit x
    assign w_prod = i_pos_x * 9'd373;
    assign w_slot = w_prod[17:13];
    assign w_base = 9'(w_slot * SLOT_PITCH);
    assign w_lx   = 5'(i_pos_x - w_base);
    assign w_k    = $signed({3'b000, w_slot}) - $signed({4'b0000, i_int_digits}) + 8'sd1;

    always_comb begin
        for (int s = 0; s < NUM_SEGS; s++) begin
            n_item.seg_hit[s] = (w_lx > SEG_LO_X[s]) && (w_lx < SEG_HI_X[s]) &&
                                (i_pos_y > SEG_LO_Y[s]) && (i_pos_y < SEG_HI_Y[s]);
        end
        n_item.d          = 8'(VALUE_FRAC_DIGITS) - w_k;
        n_item.slot_ok    = ({1'b0, w_slot} < 6'(MAX_SLOTS));
        n_item.in_frac    = (w_k <= $signed({5'b00000, i_frac_digits}));
        n_item.blank_zone = i_handle_neg && (w_k <= -8'sd1);
        n_item.minus_edge = (w_k == -8'sd1);
    end

    assign o_ready = (!r_valid || i_ready) && !i_hold;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

@@ sv/snr_queue.sv @@
// Two-word queue between the front and back stages.
// Depends on snr_pkg for the word type.
`timescale 1ns / 1ps

module snr_queue import snr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_word,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_word
);

    t_item      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_word  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_word;
        end
    end

endmodule

@@ sv/snr_back.sv @@
// Back stage: pick the slot's digit, apply blanking and the minus sign,
// and register the pixel level for the output. Depends on snr_pkg.
`timescale 1ns / 1ps

module snr_back import snr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_pop,
    input  t_item                 i_item,
    input  t_bcd                  i_digits,
    input  logic [NUM_DIGITS-1:0] i_nonzero,
    input  logic                  i_neg,
    input  logic                  i_show_grid,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_level
);

    logic       r_valid;
    logic [1:0] r_level, n_level;
    logic [3:0] w_dig;
    logic       w_nz_here;
    logic       w_nz_next;
    logic [6:0] w_lit;

    assign w_dig     = digit_at(i_digits, i_item.d);
    assign w_nz_here = nonzero_at(i_nonzero, i_item.d);
    assign w_nz_next = nonzero_at(i_nonzero, i_item.d - 8'sd1);

    always_comb begin
        w_lit = i_item.in_frac ? (i_item.seg_hit & digit_segs(w_dig)) : 7'h00;
        if (i_item.blank_zone && !w_nz_here) begin
            w_lit = 7'h00;
            if (i_neg && (i_item.minus_edge || w_nz_next)) begin
                w_lit = i_item.seg_hit & SEG_CENTRE;
            end
        end
        if (!i_item.slot_ok) begin
            n_level = LEVEL_OFF;
        end else if (w_lit != 7'h00) begin
            n_level = LEVEL_LIT;
        end else if (i_show_grid && (i_item.seg_hit != 7'h00)) begin
            n_level = LEVEL_GRID;
        end else begin
            n_level = LEVEL_OFF;
        end
    end

    assign o_pop   = i_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_level = r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_level <= n_level;
        end
    end

endmodule

@@ sv/seven_segment_number_renderer_unit.sv @@
// A pixel word passes the front register, the queue and the back level register.
// Throughput: one pixel word per clock, independent of output stalls up to the queue.
// After a write to display_value the input stalls while the decimal
// converter shifts the magnitude through its digit registers.
// Reset is synchronous, active low: pipeline empty, registers to their defaults.
// Top level; depends on snr_pkg, snr_bcd_conv, snr_front, snr_queue, snr_back.
`timescale 1ns / 1ps

module seven_segment_number_renderer_unit import snr_pkg::*; #(
    parameter int MAX_SLOTS         = 16,
    parameter int VALUE_FRAC_DIGITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [8:0]  i_pos_x,
    input  logic [6:0]  i_pos_y,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_pixel_level,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0]            r_int_digits;
    logic [2:0]            r_frac_digits;
    logic                  r_show_grid;
    logic                  r_handle_neg;
    logic [30:0]           r_value;
    logic                  w_wr;
    logic                  w_start;
    logic                  w_busy;
    t_bcd                  w_digits;
    logic [NUM_DIGITS-1:0] w_nonzero;
    logic                  w_f_valid;
    t_item                 w_f_item;
    logic                  w_q_full;
    logic                  w_q_empty;
    logic                  w_q_pop;
    t_item                 w_q_item;

    assign pready  = 1'b1;
    assign w_wr    = psel && penable && pwrite && pready;
    assign w_start = w_wr && (paddr[4:2] == REG_VALUE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_digits  <= RST_INT_DIGITS;
            r_frac_digits <= RST_FRAC_DIGITS;
            r_show_grid   <= RST_SHOW_GRID;
            r_handle_neg  <= RST_HANDLE_NEG;
            r_value       <= RST_VALUE;
        end else if (w_wr) begin
            case (paddr[4:2])
                REG_INT_DIGITS:  r_int_digits  <= pwdata[3:0];
                REG_FRAC_DIGITS: r_frac_digits <= pwdata[2:0];
                REG_SHOW_GRID:   r_show_grid   <= pwdata[0];
                REG_HANDLE_NEG:  r_handle_neg  <= pwdata[0];
                REG_VALUE:       r_value       <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_INT_DIGITS:  prdata = {28'd0, r_int_digits};
            REG_FRAC_DIGITS: prdata = {29'd0, r_frac_digits};
            REG_SHOW_GRID:   prdata = {31'd0, r_show_grid};
            REG_HANDLE_NEG:  prdata = {31'd0, r_handle_neg};
            REG_VALUE:       prdata = {1'b0, r_value};
            default:         prdata = 32'd0;
        endcase
    end

    snr_bcd_conv u_conv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_value   (pwdata[30:0]),
        .o_busy    (w_busy),
        .o_digits  (w_digits),
        .o_nonzero (w_nonzero)
    );

    snr_front #(
        .MAX_SLOTS         (MAX_SLOTS),
        .VALUE_FRAC_DIGITS (VALUE_FRAC_DIGITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_hold        (w_busy),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_int_digits  (r_int_digits),
        .i_frac_digits (r_frac_digits),
        .i_handle_neg  (r_handle_neg),
        .o_valid       (w_f_valid),
        .i_ready       (!w_q_full),
        .o_item        (w_f_item)
    );

    snr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid && !w_q_full),
        .i_word  (w_f_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_word  (w_q_item)
    );

    snr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!w_q_empty),
        .o_pop       (w_q_pop),
        .i_item      (w_q_item),
        .i_digits    (w_digits),
        .i_nonzero   (w_nonzero),
        .i_neg       (r_value[30]),
        .i_show_grid (r_show_grid),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_level     (o_pixel_level)
    );

endmodule

@@ sv/snr_checker.sv @@
// Port-level checker for the renderer, bound to the top level.
// Depends on snr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module snr_checker import snr_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_pixel_level,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [4:0]  paddr,
    input logic        pready
);

    `SNR_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_level), "output word dropped or changed while stalled")
    `SNR_ASSERT(a_level_code, i_clk, i_rst_n, o_out_valid |-> o_pixel_level != 2'd3, "undefined pixel level")
    `SNR_ASSERT(a_conv_stall, i_clk, i_rst_n, psel && penable && pwrite && paddr[4:2] == REG_VALUE |=> !o_in_ready, "input taken during value conversion")
    `SNR_ASSERT(a_empty_after_reset, i_clk, i_rst_n, $rose(i_rst_n) |-> !o_out_valid, "output valid right after reset")
    `SNR_ASSERT_ALWAYS(a_pready, i_clk, pready, "pready low")

endmodule

bind seven_segment_number_renderer_unit snr_checker u_snr_checker (.*);
